### design/rmq_pkg.sv
package rmq_pkg;

    localparam int FW = 18;
    localparam int THR_W = 17;
    localparam int BR_W = 2;
    localparam int LANES = 3;
    localparam int FIELD_MAX = 131071;
    localparam int FIELD_MIN_MAG = 131072;

    localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
    localparam logic [BR_W-1:0] BR_COL0 = 2'd1;
    localparam logic [BR_W-1:0] BR_COL1 = 2'd2;
    localparam logic [BR_W-1:0] BR_COL2 = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [BR_W-1:0]  br;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] zero;
    } ctl_t;

endpackage

### design/rmq_front.sv
module rmq_front #(
    parameter int FRAC_BITS = 16,
    parameter int RW = 20,
    parameter int NW = 19,
    parameter int VP = 36
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  take,
    input  logic signed [rmq_pkg::FW-1:0]         m00,
    input  logic signed [rmq_pkg::FW-1:0]         m01,
    input  logic signed [rmq_pkg::FW-1:0]         m02,
    input  logic signed [rmq_pkg::FW-1:0]         m10,
    input  logic signed [rmq_pkg::FW-1:0]         m11,
    input  logic signed [rmq_pkg::FW-1:0]         m12,
    input  logic signed [rmq_pkg::FW-1:0]         m20,
    input  logic signed [rmq_pkg::FW-1:0]         m21,
    input  logic signed [rmq_pkg::FW-1:0]         m22,
    input  logic [rmq_pkg::THR_W-1:0]             thr,
    output rmq_pkg::ctl_t                         ctl_reg,
    output logic [rmq_pkg::LANES*NW-1:0]          mag_reg,
    output logic [VP-1:0]                         rad_reg
);
    import rmq_pkg::*;

    localparam logic signed [RW-1:0] ONE = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [RW-1:0] e00;
    logic signed [RW-1:0] e11;
    logic signed [RW-1:0] e22;
    logic signed [RW-1:0] t;
    logic signed [RW-1:0] rad_s;
    logic [RW-2:0] rad_u;
    logic trace;
    logic col0;
    logic col1;
    logic signed [NW-1:0] num [LANES];
    ctl_t ctl_next;
    logic [LANES*NW-1:0] mag_next;
    logic [VP-1:0] rad_next;

    always_comb
    begin
        e00 = RW'(m00);
        e11 = RW'(m11);
        e22 = RW'(m22);
        t = ONE + e00 + e11 + e22;
        trace = t > $signed({{(RW-THR_W){1'b0}}, thr});
        col0 = (m00 > m11) && (m00 > m22);
        col1 = m11 > m22;
        ctl_next.valid = take;
        if (trace)
        begin
            ctl_next.br = BR_TRACE;
            rad_s = t;
            num[0] = NW'(m21) - NW'(m12);
            num[1] = NW'(m02) - NW'(m20);
            num[2] = NW'(m10) - NW'(m01);
        end
        else if (col0)
        begin
            ctl_next.br = BR_COL0;
            rad_s = ONE + e00 - e11 - e22;
            num[0] = NW'(m01) + NW'(m10);
            num[1] = NW'(m20) + NW'(m02);
            num[2] = NW'(m21) - NW'(m12);
        end
        else if (col1)
        begin
            ctl_next.br = BR_COL1;
            rad_s = ONE + e11 - e00 - e22;
            num[0] = NW'(m01) + NW'(m10);
            num[1] = NW'(m12) + NW'(m21);
            num[2] = NW'(m02) - NW'(m20);
        end
        else
        begin
            ctl_next.br = BR_COL2;
            rad_s = ONE + e22 - e00 - e11;
            num[0] = NW'(m02) + NW'(m20);
            num[1] = NW'(m12) + NW'(m21);
            num[2] = NW'(m10) - NW'(m01);
        end
        rad_u = rad_s[RW-1] ? '0 : rad_s[RW-2:0];
        rad_next = VP'(rad_u) << FRAC_BITS;
        for (int l = 0; l < LANES; l++)
        begin
            ctl_next.neg[l] = num[l][NW-1];
            ctl_next.zero[l] = (num[l] == '0);
            mag_next[l*NW +: NW] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            rad_reg <= rad_next;
        end
    end

endmodule

### design/rmq_sqrt_cell.sv
module rmq_sqrt_cell #(
    parameter int NW = 19,
    parameter int VP = 36,
    parameter int SQW = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  rmq_pkg::ctl_t                  ctl_in,
    input  logic [rmq_pkg::LANES*NW-1:0]   mag_in,
    input  logic [VP-1:0]                  rad_in,
    input  logic [SQW+2:0]                 rem_in,
    input  logic [SQW-1:0]                 root_in,
    output rmq_pkg::ctl_t                  ctl_reg,
    output logic [rmq_pkg::LANES*NW-1:0]   mag_reg,
    output logic [VP-1:0]                  rad_reg,
    output logic [SQW+2:0]                 rem_reg,
    output logic [SQW-1:0]                 root_reg
);
    import rmq_pkg::*;

    logic [SQW+2:0] rem_sh;
    logic [SQW+2:0] trial;
    logic [SQW+2:0] rem_next;
    logic [SQW-1:0] root_next;

    always_comb
    begin
        rem_sh = {rem_in[SQW:0], rad_in[VP-1:VP-2]};
        trial = {1'b0, root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next = rem_sh - trial;
            root_next = {root_in[SQW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            root_next = {root_in[SQW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_in;
            rad_reg <= {rad_in[VP-3:0], 2'b00};
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

### design/rmq_div_cell.sv
module rmq_div_cell #(
    parameter int SQW = 18,
    parameter int DW = 36,
    parameter int QW = 18,
    parameter int K = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  rmq_pkg::ctl_t                  ctl_in,
    input  logic [SQW-1:0]                 root_in,
    input  logic [rmq_pkg::LANES*DW-1:0]   rem_in,
    input  logic [rmq_pkg::LANES*QW-1:0]   quo_in,
    output rmq_pkg::ctl_t                  ctl_reg,
    output logic [SQW-1:0]                 root_reg,
    output logic [rmq_pkg::LANES*DW-1:0]   rem_reg,
    output logic [rmq_pkg::LANES*QW-1:0]   quo_reg
);
    import rmq_pkg::*;

    localparam int XW = DW + QW + SQW + 2;

    logic [XW-1:0] dvs;
    logic [XW-1:0] rem_x;
    logic [LANES*DW-1:0] rem_next;
    logic [LANES*QW-1:0] quo_next;

    always_comb
    begin
        dvs = XW'(root_in) << (K + 1);
        for (int l = 0; l < LANES; l++)
        begin
            rem_x = XW'(rem_in[l*DW +: DW]);
            if (rem_x >= dvs)
            begin
                rem_next[l*DW +: DW] = rem_in[l*DW +: DW] - dvs[DW-1:0];
                quo_next[l*QW +: QW] = {quo_in[l*QW +: QW-1], 1'b1};
            end
            else
            begin
                rem_next[l*DW +: DW] = rem_in[l*DW +: DW];
                quo_next[l*QW +: QW] = {quo_in[l*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= root_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

### design/rmq_out.sv
module rmq_out #(
    parameter int FRAC_BITS = 16,
    parameter int SQW = 18,
    parameter int QW = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  rmq_pkg::ctl_t                       ctl_in,
    input  logic [SQW-1:0]                      root_in,
    input  logic [rmq_pkg::LANES*QW-1:0]        quo_in,
    output logic                                valid_reg,
    output logic signed [rmq_pkg::FW-1:0]       qx_reg,
    output logic signed [rmq_pkg::FW-1:0]       qy_reg,
    output logic signed [rmq_pkg::FW-1:0]       qz_reg,
    output logic signed [rmq_pkg::FW-1:0]       qw_reg,
    output logic [rmq_pkg::BR_W-1:0]            br_reg
);
    import rmq_pkg::*;

    localparam int EW = QW + SQW + FW;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int LIMP_I = (ONE_I < FIELD_MAX) ? ONE_I : FIELD_MAX;
    localparam int LIMN_I = (ONE_I < FIELD_MIN_MAG) ? ONE_I : FIELD_MIN_MAG;
    localparam logic [EW-1:0] LIMP = EW'(LIMP_I);
    localparam logic [EW-1:0] LIMN = EW'(LIMN_I);

    logic [EW-1:0] q;
    logic [EW-1:0] m;
    logic [EW-1:0] w;
    logic [FW-1:0] lane [LANES];
    logic [FW-1:0] wv;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            q = EW'(quo_in[l*QW +: QW]);
            m = '0;
            if (ctl_in.zero[l])
            begin
                lane[l] = '0;
            end
            else if (ctl_in.neg[l])
            begin
                m = (q > LIMN) ? LIMN : q;
                lane[l] = FW'(-m);
            end
            else
            begin
                m = (q > LIMP) ? LIMP : q;
                lane[l] = FW'(m);
            end
        end
        w = (EW'(root_in) + EW'(1)) >> 1;
        wv = (w > LIMP) ? FW'(LIMP) : FW'(w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            br_reg <= ctl_in.br;
            case (ctl_in.br)
                BR_TRACE:
                begin
                    qx_reg <= lane[0];
                    qy_reg <= lane[1];
                    qz_reg <= lane[2];
                    qw_reg <= wv;
                end
                BR_COL0:
                begin
                    qx_reg <= wv;
                    qy_reg <= lane[0];
                    qz_reg <= lane[1];
                    qw_reg <= lane[2];
                end
                BR_COL1:
                begin
                    qx_reg <= lane[0];
                    qy_reg <= wv;
                    qz_reg <= lane[1];
                    qw_reg <= lane[2];
                end
                default:
                begin
                    qx_reg <= lane[0];
                    qy_reg <= lane[1];
                    qz_reg <= wv;
                    qw_reg <= lane[2];
                end
            endcase
        end
    end

endmodule

### design/rotation_matrix_to_quaternion_core.sv
// An accepted word passes through one front stage, one square root cell per
// root bit, one divider cell per quotient bit and one output register on
// its way to the result.
// Throughput: one word per cycle; the whole chain advances together and
// holds only while a result waits at the output.
// Reset clears every valid flag and sets the trace threshold (thr_reg) to zero.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmq_pkg::THR_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmq_pkg::FW-1:0]       m00,
    input  logic signed [rmq_pkg::FW-1:0]       m01,
    input  logic signed [rmq_pkg::FW-1:0]       m02,
    input  logic signed [rmq_pkg::FW-1:0]       m10,
    input  logic signed [rmq_pkg::FW-1:0]       m11,
    input  logic signed [rmq_pkg::FW-1:0]       m12,
    input  logic signed [rmq_pkg::FW-1:0]       m20,
    input  logic signed [rmq_pkg::FW-1:0]       m21,
    input  logic signed [rmq_pkg::FW-1:0]       m22,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmq_pkg::FW-1:0]       qx,
    output logic signed [rmq_pkg::FW-1:0]       qy,
    output logic signed [rmq_pkg::FW-1:0]       qz,
    output logic signed [rmq_pkg::FW-1:0]       qw,
    output logic [rmq_pkg::BR_W-1:0]            branch_used
);
    import rmq_pkg::*;

    localparam int RW = ((FRAC_BITS + 1 > FW) ? FRAC_BITS + 1 : FW) + 2;
    localparam int NW = FW + 1;
    localparam int VW = RW - 1 + FRAC_BITS;
    localparam int SQW = (VW + 1) / 2;
    localparam int VP = 2 * SQW;
    localparam int DW = NW + FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int LIMP_I = (ONE_I < FIELD_MAX) ? ONE_I : FIELD_MAX;
    localparam logic signed [FW:0] LIMP_S = (FW+1)'(LIMP_I);

    logic en;
    logic [THR_W-1:0] thr_reg;

    ctl_t sq_ctl [SQW+1];
    logic [LANES*NW-1:0] sq_mag [SQW+1];
    logic [VP-1:0] sq_rad [SQW+1];
    logic [SQW+2:0] sq_rem [SQW+1];
    logic [SQW-1:0] sq_root [SQW+1];

    ctl_t dv_ctl [QW+1];
    logic [SQW-1:0] dv_root [QW+1];
    logic [LANES*DW-1:0] dv_rem [QW+1];
    logic [LANES*QW-1:0] dv_quo [QW+1];

    assign en = !out_valid || !out_stall;
    assign in_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RW        (RW),
        .NW        (NW),
        .VP        (VP)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .take    (in_valid && en),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22),
        .thr     (thr_reg),
        .ctl_reg (sq_ctl[0]),
        .mag_reg (sq_mag[0]),
        .rad_reg (sq_rad[0])
    );

    assign sq_rem[0] = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < SQW; i++)
    begin : g_sqrt
        rmq_sqrt_cell #(
            .NW  (NW),
            .VP  (VP),
            .SQW (SQW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (sq_ctl[i]),
            .mag_in   (sq_mag[i]),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .ctl_reg  (sq_ctl[i+1]),
            .mag_reg  (sq_mag[i+1]),
            .rad_reg  (sq_rad[i+1]),
            .rem_reg  (sq_rem[i+1]),
            .root_reg (sq_root[i+1])
        );
    end

    assign dv_ctl[0] = sq_ctl[SQW];
    assign dv_root[0] = sq_root[SQW];
    assign dv_quo[0] = '0;

    for (genvar l = 0; l < LANES; l++)
    begin : g_seed
        assign dv_rem[0][l*DW +: DW] = (DW'(sq_mag[SQW][l*NW +: NW]) << FRAC_BITS)
                                       + DW'(sq_root[SQW]);
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        rmq_div_cell #(
            .SQW (SQW),
            .DW  (DW),
            .QW  (QW),
            .K   (QW - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (dv_ctl[j]),
            .root_in  (dv_root[j]),
            .rem_in   (dv_rem[j]),
            .quo_in   (dv_quo[j]),
            .ctl_reg  (dv_ctl[j+1]),
            .root_reg (dv_root[j+1]),
            .rem_reg  (dv_rem[j+1]),
            .quo_reg  (dv_quo[j+1])
        );
    end

    rmq_out #(
        .FRAC_BITS (FRAC_BITS),
        .SQW       (SQW),
        .QW        (QW)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (dv_ctl[QW]),
        .root_in   (dv_root[QW]),
        .quo_in    (dv_quo[QW]),
        .valid_reg (out_valid),
        .qx_reg    (qx),
        .qy_reg    (qy),
        .qz_reg    (qz),
        .qw_reg    (qw),
        .br_reg    (branch_used)
    );

    a_trace_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (branch_used == BR_TRACE) |-> !qw[FW-1])
        else $error("trace branch produced a negative w");

    a_col0_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (branch_used == BR_COL0) |-> !qx[FW-1])
        else $error("column 0 branch produced a negative x");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((FW+1)'(qx) <= LIMP_S) && ((FW+1)'(qy) <= LIMP_S)
                   && ((FW+1)'(qz) <= LIMP_S) && ((FW+1)'(qw) <= LIMP_S))
        else $error("quaternion component above positive limit");

endmodule
